// ===== rtl/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg
// shared constants, types and key mapping functions of the radix sorter
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DIGIT_BITS_DEF = 8;
  localparam int KEY_W          = 64;

  typedef enum logic [1:0] {
    KT_U32 = 2'd0,
    KT_S32 = 2'd1,
    KT_F32 = 2'd2,
    KT_F64 = 2'd3
  } key_type_t;

  function automatic logic [KEY_W-1:0] to_ordered(input logic [KEY_W-1:0] v,
                                                  input key_type_t t);
    logic [31:0] w;
    w = v[31:0];
    case (t)
      KT_U32: to_ordered = {32'd0, w};
      KT_S32: to_ordered = {32'd0, w ^ 32'h8000_0000};
      KT_F32: to_ordered = {32'd0, w[31] ? ~w : (w ^ 32'h8000_0000)};
      default: to_ordered = v[63] ? ~v : (v ^ 64'h8000_0000_0000_0000);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] from_ordered(input logic [KEY_W-1:0] v,
                                                    input key_type_t t);
    logic [31:0] w;
    w = v[31:0];
    case (t)
      KT_U32: from_ordered = {32'd0, w};
      KT_S32: from_ordered = {32'd0, w ^ 32'h8000_0000};
      KT_F32: from_ordered = {32'd0, w[31] ? (w ^ 32'h8000_0000) : ~w};
      default: from_ordered = v[63] ? (v ^ 64'h8000_0000_0000_0000) : ~v;
    endcase
  endfunction

endpackage

// ===== rtl/lrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrs_ctrl
// sequencer and memories: load, map, clear, count, prefix sum, scatter, copy back, stream
// ----------------------------------------------------------------------------
module lrs_ctrl #(
  parameter int CAPACITY   = lrs_pkg::CAPACITY_DEF,
  parameter int DIGIT_BITS = lrs_pkg::DIGIT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [63:0]             in_key,
  input  logic                    in_last,
  input  lrs_pkg::key_type_t      key_type,
  output logic                    out_valid,
  output logic [63:0]             out_sorted_key,
  output logic                    out_last_out,
  output logic                    out_overflow
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int BINS = 1 << DIGIT_BITS;
  localparam int PW   = $clog2(64 / DIGIT_BITS + 2);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_MAP   = 9'b000000010,
    S_CLR   = 9'b000000100,
    S_CNT   = 9'b000001000,
    S_SUM   = 9'b000010000,
    S_SCAT  = 9'b000100000,
    S_COPY  = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_WAIT  = 9'b100000000
  } state_t;

  logic [63:0]         kmem [CAPACITY];
  logic [63:0]         smem [CAPACITY];
  logic [CW-1:0]       cmem [BINS];

  state_t              state_r;
  logic [CW-1:0]       n_r;
  logic                drop_r;
  logic [DIGIT_BITS:0] idx_r;
  logic [PW-1:0]       pass_r;
  logic [1:0]          ph_r;
  logic [63:0]         krd_r;
  logic [CW-1:0]       crd_r;
  logic [CW-1:0]       acc_r;
  logic [63:0]         srd_r;
  logic                ov_r;
  logic [63:0]         okey_r;
  logic                olast_r;
  logic                oovf_r;
  lrs_pkg::key_type_t  kt_r;

  logic [PW-1:0]       npass;
  logic [6:0]          sh;
  logic [DIGIT_BITS-1:0] dig;
  logic [CW-1:0]       pos;
  logic                out_go;
  logic                accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_LOAD);
  assign npass  = (kt_r == lrs_pkg::KT_F64) ? PW'((64 + DIGIT_BITS - 1) / DIGIT_BITS)
                                            : PW'((32 + DIGIT_BITS - 1) / DIGIT_BITS);
  assign sh     = 7'(pass_r * DIGIT_BITS);
  assign dig    = DIGIT_BITS'(krd_r >> sh);
  assign pos    = crd_r - 1'b1;
  assign out_go = (state_r == S_OUT) && (idx_r != (DIGIT_BITS+1)'(n_r));

  // ph_r steps through issue read, use read data, write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      n_r     <= '0;
      drop_r  <= 1'b0;
      idx_r   <= '0;
      pass_r  <= '0;
      ph_r    <= 2'd0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (n_r < CW'(CAPACITY)) begin
              kmem[n_r[AW-1:0]] <= in_key;
              n_r <= n_r + 1'b1;
            end else begin
              drop_r <= 1'b1;
            end
            if (in_last) begin
              kt_r   <= key_type;
              idx_r  <= '0;
              ph_r   <= 2'd0;
              pass_r <= '0;
              state_r <= S_MAP;
            end
          end
        end
        S_MAP: begin
          if (ph_r == 2'd0) begin
            if (idx_r == (DIGIT_BITS+1)'(n_r)) begin
              idx_r <= '0;
              state_r <= S_CLR;
            end else begin
              krd_r <= kmem[idx_r[AW-1:0]];
              ph_r  <= 2'd1;
            end
          end else begin
            kmem[idx_r[AW-1:0]] <= lrs_pkg::to_ordered(krd_r, kt_r);
            idx_r <= idx_r + 1'b1;
            ph_r  <= 2'd0;
          end
        end
        S_CLR: begin
          cmem[idx_r[DIGIT_BITS-1:0]] <= '0;
          if (idx_r == (DIGIT_BITS+1)'(BINS - 1)) begin
            idx_r <= '0;
            ph_r  <= 2'd0;
            state_r <= S_CNT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_CNT: begin
          // read key, then read bin, then write bin+1
          if (ph_r == 2'd0) begin
            if (idx_r == (DIGIT_BITS+1)'(n_r)) begin
              idx_r <= '0;
              acc_r <= '0;
              state_r <= S_SUM;
            end else begin
              krd_r <= kmem[idx_r[AW-1:0]];
              ph_r  <= 2'd1;
            end
          end else if (ph_r == 2'd1) begin
            crd_r <= cmem[dig];
            ph_r  <= 2'd2;
          end else begin
            cmem[dig] <= crd_r + 1'b1;
            idx_r <= idx_r + 1'b1;
            ph_r  <= 2'd0;
          end
        end
        S_SUM: begin
          // read bin idx while writing back the running sum of bin idx-1
          if (idx_r != (DIGIT_BITS+1)'(BINS)) begin
            crd_r <= cmem[idx_r[DIGIT_BITS-1:0]];
          end
          if (ph_r != 2'd0) begin
            cmem[DIGIT_BITS'(idx_r - 1'b1)] <= acc_r + crd_r;
            acc_r <= acc_r + crd_r;
          end
          if (idx_r == (DIGIT_BITS+1)'(BINS)) begin
            idx_r <= (DIGIT_BITS+1)'(n_r);
            ph_r  <= 2'd0;
            state_r <= S_SCAT;
          end else begin
            idx_r <= idx_r + 1'b1;
            ph_r  <= 2'd1;
          end
        end
        S_SCAT: begin
          if (ph_r == 2'd0) begin
            if (idx_r == '0) begin
              state_r <= S_COPY;
            end else begin
              krd_r <= kmem[AW'(idx_r - 1'b1)];
              ph_r  <= 2'd1;
            end
          end else if (ph_r == 2'd1) begin
            crd_r <= cmem[dig];
            ph_r  <= 2'd2;
          end else begin
            cmem[dig] <= pos;
            smem[pos[AW-1:0]] <= krd_r;
            idx_r <= idx_r - 1'b1;
            ph_r  <= 2'd0;
          end
        end
        S_COPY: begin
          if (ph_r == 2'd0) begin
            if (idx_r == (DIGIT_BITS+1)'(n_r)) begin
              idx_r <= '0;
              if (pass_r + 1'b1 == npass) begin
                state_r <= S_OUT;
              end else begin
                pass_r <= pass_r + 1'b1;
                state_r <= S_CLR;
              end
            end else begin
              srd_r <= smem[idx_r[AW-1:0]];
              ph_r  <= 2'd1;
            end
          end else begin
            kmem[idx_r[AW-1:0]] <= srd_r;
            idx_r <= idx_r + 1'b1;
            ph_r  <= 2'd0;
          end
        end
        S_OUT: begin
          if (idx_r == (DIGIT_BITS+1)'(n_r)) begin
            state_r <= S_WAIT;
          end else begin
            srd_r   <= kmem[idx_r[AW-1:0]];
            olast_r <= (idx_r + 1'b1 == (DIGIT_BITS+1)'(n_r));
            oovf_r  <= drop_r;
            idx_r   <= idx_r + 1'b1;
          end
        end
        S_WAIT: begin
          n_r    <= '0;
          drop_r <= 1'b0;
          state_r <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= out_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) okey_r <= '0;
    else if (ov_r) okey_r <= lrs_pkg::from_ordered(srd_r, kt_r);
  end

  logic                  oval_r;
  logic                  ol_r, oo_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else begin
      oval_r <= ov_r;
      ol_r   <= olast_r;
      oo_r   <= oovf_r;
    end
  end

  assign out_valid      = oval_r;
  assign out_sorted_key = okey_r;
  assign out_last_out   = ol_r;
  assign out_overflow   = oo_r;

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("beat while not busy");
  a_load_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(CAPACITY)) else $error("fill count too large");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |=> !out_valid) else $error("beat after last");

endmodule

// ===== rtl/lsd_radix_sorter_top.sv =====
// ----------------------------------------------------------------------------
// lsd_radix_sorter_top
// batch lsd radix sorter with apb key type register
// ----------------------------------------------------------------------------
// Keys load one per cycle while start is high, until in_last. A map step
// follows, then 4 passes (8 for key_type 3), each of which clears the 256-bin
// digit count memory, then counts, prefix sums, scatters and copies back.
// Results then stream one per cycle on out_valid, registered through ov_r and
// oval_r after the last pass, and cannot be stalled. busy drops the cycle
// after the last beat.
module lsd_radix_sorter_top #(
  parameter int CAPACITY   = lrs_pkg::CAPACITY_DEF,
  parameter int DIGIT_BITS = lrs_pkg::DIGIT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_key,
  input  logic        in_last,
  output logic        out_valid,
  output logic [63:0] out_sorted_key,
  output logic        out_last_out,
  output logic        out_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lrs_pkg::key_type_t kt_r;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, kt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) kt_r <= lrs_pkg::KT_U32;
    else if (psel && penable && pwrite && paddr == 2'd0)
      kt_r <= lrs_pkg::key_type_t'(pwdata[1:0]);
  end

  lrs_ctrl #(.CAPACITY(CAPACITY), .DIGIT_BITS(DIGIT_BITS)) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_key, .in_last,
    .key_type(kt_r), .out_valid, .out_sorted_key, .out_last_out, .out_overflow
  );

endmodule
